// ===== rtl/weno5_pkg.sv =====
// package: payload types, operation codes and arithmetic helpers for the weno5 block
package weno5_pkg;

   localparam int SAMPLE_W = 32;
   localparam int WEIGHT_W = 21;
   localparam int EPS_W    = 32;

   localparam logic [EPS_W-1:0] EPS_RESET = 32'd1099512;

   localparam logic [1:0] OP_CAND   = 2'd0;
   localparam logic [1:0] OP_WEIGHT = 2'd1;
   localparam logic [1:0] OP_FULL   = 2'd2;

   // (2^(16*i) - 1) / 3 for the chunked divide by three
   localparam logic [63:0] DIV3_SPLIT [4] = '{
      64'd0, 64'd21845, 64'd1431655765, 64'd93824992236885
   };

   typedef struct packed {
      logic [1:0]                 operation;
      logic                       direction;
      logic signed [SAMPLE_W-1:0] sample_m2;
      logic signed [SAMPLE_W-1:0] sample_m1;
      logic signed [SAMPLE_W-1:0] sample_center;
      logic signed [SAMPLE_W-1:0] sample_p1;
      logic signed [SAMPLE_W-1:0] sample_p2;
   } weno5_req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] cand0;
      logic signed [SAMPLE_W-1:0] cand1;
      logic signed [SAMPLE_W-1:0] cand2;
      logic [WEIGHT_W-1:0]        weight0;
      logic [WEIGHT_W-1:0]        weight1;
      logic [WEIGHT_W-1:0]        weight2;
      logic signed [SAMPLE_W-1:0] recon_value;
   } weno5_rsp_type;

   // floor(x / 3): per 16-bit chunk reciprocal, remainders folded back in
   function automatic logic [63:0] div3_u64(input logic [63:0] x);
      logic [15:0] c;
      logic [32:0] prod;
      logic [15:0] q;
      logic [15:0] q3;
      logic [1:0]  r;
      logic [63:0] acc;
      logic [3:0]  rsum;
      logic [8:0]  rs11;
      acc  = '0;
      rsum = '0;
      for (int i = 0; i < 4; i++) begin
         c    = x[16*i +: 16];
         prod = {17'd0, c} * 33'd43691;
         q    = prod[32:17];
         q3   = q + {q[14:0], 1'b0};
         r    = 2'(c - q3);
         acc  = acc + ({48'd0, q} << (16*i));
         if (r == 2'd2) begin
            acc = acc + {DIV3_SPLIT[i][62:0], 1'b0};
         end else if (r == 2'd1) begin
            acc = acc + DIV3_SPLIT[i];
         end
         rsum = rsum + {2'd0, r};
      end
      rs11 = {5'd0, rsum} * 9'd11;
      return acc + {60'd0, rs11[8:5]};
   endfunction

   function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat32(input logic signed [39:0] x);
      logic signed [SAMPLE_W-1:0] res;
      if (x > 40'sd2147483647) begin
         res = 32'sh7FFFFFFF;
      end else if (x < -40'sd2147483648) begin
         res = 32'sh80000000;
      end else begin
         res = x[SAMPLE_W-1:0];
      end
      return res;
   endfunction

endpackage

// ===== rtl/weno5_reconstruction_top.sv =====
// top level: pipelined fifth-order weno-js interface reconstruction
// throughput: one item per cycle; a stalled result freezes the whole pipeline
// reset: synchronous, clears every stage valid bit, epsilon returns to 1099512
// the depth is set by the two bit-per-stage dividers (ratio 20 stages, weight 21)
module weno5_reconstruction_top
   import weno5_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  weno5_req_type        req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output weno5_rsp_type        rsp_data,
   input  logic                 csr_wr_en,
   input  logic [EPS_W-1:0]     csr_wr_data
);

   localparam int NUM_STG  = 57;
   localparam int STG_LAST = NUM_STG - 1;
   localparam int RD_STEPS = 20;  // ratio quotient bits
   localparam int WD_STEPS = 21;  // weight quotient bits
   localparam int CAND_DLY = 52;  // candidate carried from stage 4 to stage 55
   localparam int OP_DLY   = 55;  // operation carried from stage 1 to stage 55
   localparam int NW       = 38;  // numerator and difference width
   localparam int AW       = 44;  // alpha and alpha-sum width

   // stage valid bits, one global advance
   logic [NUM_STG-1:0] vld_ff, vld_in;
   logic               adv;

   logic [EPS_W-1:0]   eps_ff, eps_in;

   // stage 0: input register
   weno5_req_type      in_ff;
   logic [1:0]         op_ff [OP_DLY], op_in [OP_DLY];

   // stage 1: stencil numerators and smoothness differences
   logic signed [NW-1:0] num_ff [3], num_in [3];
   logic signed [NW-1:0] tt_ff [6], tt_in [6];

   // stage 2: magnitudes
   logic [NW-1:0]      cmag_ff [3], cmag_in [3];
   logic               cneg_ff [3], cneg_in [3];
   logic [31:0]        tlow_ff [6], tlow_in [6];
   logic               tbig_ff [6], tbig_in [6];

   // stage 3: squares, candidate quotient
   logic [63:0]        sq_ff [6], sq_in [6];
   logic [63:0]        cq_ff [3], cq_in [3];
   logic               cneg3_ff [3];

   // stage 4..7: indicator sums
   logic [63:0]        s1q_ff [3], s1q_in [3];
   logic [63:0]        s2_ff [3], s2_in [3];
   logic [63:0]        q12_ff [3], q12_in [3];
   logic signed [SAMPLE_W-1:0] cand_ff [CAND_DLY][3], cand_in [CAND_DLY][3];
   logic [63:0]        x_ff [3], x_in [3];
   logic [63:0]        s1q5_ff [3];
   logic [63:0]        beta_ff [3], beta_in [3];
   logic [63:0]        b_ff [3], b_in [3];

   // stages 8..28: ratio divider, index 0 holds the initial remainder
   logic [63:0]        rrem_ff [RD_STEPS+1][3], rrem_in [RD_STEPS+1][3];
   logic [63:0]        rb_ff [RD_STEPS+1][3], rb_in [RD_STEPS+1][3];
   logic [RD_STEPS-1:0] rq_ff [RD_STEPS+1][3], rq_in [RD_STEPS+1][3];
   logic               rone_ff [RD_STEPS+1][3], rone_in [RD_STEPS+1][3];
   logic [64:0]        rdiff [RD_STEPS+1][3];
   logic [63:0]        bmin;

   // stages 29..31: alpha
   logic [20:0]        rval [3];
   logic [41:0]        r2_ff [3], r2_in [3];
   logic [AW-1:0]      alpha_ff [3], alpha_in [3];
   logic [AW-1:0]      alpha31_ff [3];
   logic [AW-1:0]      asum_ff, asum_in;

   // stages 32..53: weight divider
   logic [63:0]        wrem_ff [WD_STEPS+1][3], wrem_in [WD_STEPS+1][3];
   logic [WD_STEPS-1:0] wq_ff [WD_STEPS+1][3], wq_in [WD_STEPS+1][3];
   logic [AW-1:0]      wd_ff [WD_STEPS+1], wd_in [WD_STEPS+1];
   logic [64:0]        wdiff [WD_STEPS+1][3];

   // stages 54..56: weighted sum and output
   logic [WEIGHT_W-1:0] wt_ff [3], wt55_ff [3];
   logic signed [53:0] prod_ff [3], prod_in [3];
   logic signed [55:0] acc;
   logic signed [35:0] rs_ff, rs_in;
   weno5_rsp_type      rsp_ff, rsp_in;

   logic signed [NW-1:0] fm2, fm1, f0, fp1, fp2;
   logic signed [NW-1:0] cs [3];

   // whole pipeline moves unless a finished item waits at the output
   assign adv       = !vld_ff[STG_LAST] || rsp_ready;
   assign req_ready = adv;
   assign vld_in    = {vld_ff[NUM_STG-2:0], req_valid};
   assign eps_in    = csr_wr_en ? csr_wr_data : eps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         eps_ff <= EPS_RESET;
      end else begin
         eps_ff <= eps_in;
         if (adv) begin
            vld_ff <= vld_in;
         end
      end
   end

   always_comb begin
      // direction mirrors the stencil about the centre sample
      if (in_ff.direction) begin
         fm2 = NW'(in_ff.sample_p2);
         fm1 = NW'(in_ff.sample_p1);
         fp1 = NW'(in_ff.sample_m1);
         fp2 = NW'(in_ff.sample_m2);
      end else begin
         fm2 = NW'(in_ff.sample_m2);
         fm1 = NW'(in_ff.sample_m1);
         fp1 = NW'(in_ff.sample_p1);
         fp2 = NW'(in_ff.sample_p2);
      end
      f0 = NW'(in_ff.sample_center);

      op_in[0] = in_ff.operation;
      for (int i = 1; i < OP_DLY; i++) begin
         op_in[i] = op_ff[i-1];
      end

      // candidate numerators, six times the polynomial value
      num_in[0] = (fm2 <<< 1) - fm1 * 38'sd7 + f0 * 38'sd11;
      num_in[1] = f0 * 38'sd5 + (fp1 <<< 1) - fm1;
      num_in[2] = (f0 <<< 1) + fp1 * 38'sd5 - fp2;

      // jiang-shu differences: first and second derivative per substencil
      tt_in[0] = fm2 - (fm1 <<< 2) + f0 * 38'sd3;
      tt_in[1] = fm2 - (fm1 <<< 1) + f0;
      tt_in[2] = fm1 - fp1;
      tt_in[3] = fm1 - (f0 <<< 1) + fp1;
      tt_in[4] = f0 * 38'sd3 - (fp1 <<< 2) + fp2;
      tt_in[5] = f0 - (fp1 <<< 1) + fp2;

      for (int k = 0; k < 3; k++) begin
         cneg_in[k] = num_ff[k][NW-1];
         cmag_in[k] = (num_ff[k][NW-1] ? NW'(-num_ff[k]) : NW'(num_ff[k])) + NW'(3);
         // rounded divide by six: halve, then divide by three
         cq_in[k]   = div3_u64({{(64-NW+1){1'b0}}, cmag_ff[k][NW-1:1]});
         cs[k]      = cneg3_ff[k] ? -$signed(cq_ff[k][NW-1:0]) : $signed(cq_ff[k][NW-1:0]);
         cand_in[0][k] = sat32(40'(cs[k]));
      end
      for (int d = 1; d < CAND_DLY; d++) begin
         for (int k = 0; k < 3; k++) begin
            cand_in[d][k] = cand_ff[d-1][k];
         end
      end

      for (int j = 0; j < 6; j++) begin
         tlow_in[j] = tt_ff[j][NW-1] ? 32'(-tt_ff[j]) : tt_ff[j][31:0];
         tbig_in[j] = tt_ff[j][NW-1] ? ((-tt_ff[j]) >= 38'sd4294967296)
                                     : (tt_ff[j] >= 38'sd4294967296);
         // squares saturate once the magnitude reaches 2^32
         sq_in[j]   = tbig_ff[j] ? '1 : ({32'd0, tlow_ff[j]} * {32'd0, tlow_ff[j]});
      end

      for (int k = 0; k < 3; k++) begin
         s1q_in[k]  = {2'd0, sq_ff[2*k][63:2]};
         s2_in[k]   = sq_ff[2*k+1];
         q12_in[k]  = div3_u64({2'd0, sq_ff[2*k+1][63:2]});
         x_in[k]    = sat_add64(s2_ff[k], q12_ff[k]);
         beta_in[k] = sat_add64(s1q5_ff[k], x_ff[k]);
         b_in[k]    = sat_add64(beta_ff[k], {32'd0, eps_ff});
      end

      // smallest regularised indicator is the ratio numerator
      bmin = b_ff[0];
      if (b_ff[1] < bmin) begin
         bmin = b_ff[1];
      end
      if (b_ff[2] < bmin) begin
         bmin = b_ff[2];
      end

      for (int k = 0; k < 3; k++) begin
         rrem_in[0][k] = bmin;
         rb_in[0][k]   = b_ff[k];
         rq_in[0][k]   = '0;
         rone_in[0][k] = (b_ff[k] <= bmin);
         rdiff[0][k]   = '0;
      end
      // restoring division, one quotient bit per stage
      for (int j = 1; j <= RD_STEPS; j++) begin
         for (int k = 0; k < 3; k++) begin
            rdiff[j][k]   = {rrem_ff[j-1][k], 1'b0} - {1'b0, rb_ff[j-1][k]};
            rrem_in[j][k] = rdiff[j][k][64] ? {rrem_ff[j-1][k][62:0], 1'b0}
                                            : rdiff[j][k][63:0];
            rq_in[j][k]   = {rq_ff[j-1][k][RD_STEPS-2:0], !rdiff[j][k][64]};
            rb_in[j][k]   = rb_ff[j-1][k];
            rone_in[j][k] = rone_ff[j-1][k];
         end
      end

      for (int k = 0; k < 3; k++) begin
         rval[k]  = rone_ff[RD_STEPS][k] ? 21'h100000 : {1'b0, rq_ff[RD_STEPS][k]};
         r2_in[k] = {21'd0, rval[k]} * {21'd0, rval[k]};
      end
      // ideal weights 1/10, 6/10, 3/10 as 1, 6, 3
      alpha_in[0] = AW'(r2_ff[0]);
      alpha_in[1] = (AW'(r2_ff[1]) << 2) + (AW'(r2_ff[1]) << 1);
      alpha_in[2] = (AW'(r2_ff[2]) << 1) + AW'(r2_ff[2]);
      asum_in     = alpha_ff[0] + alpha_ff[1] + alpha_ff[2];

      wd_in[0] = asum_ff;
      for (int k = 0; k < 3; k++) begin
         wrem_in[0][k] = {alpha31_ff[k], 20'd0} + 64'(asum_ff >> 1);
         wq_in[0][k]   = '0;
         wdiff[0][k]   = '0;
      end
      // quotient never exceeds 2^20, so 21 bits from the top down
      for (int i = 1; i <= WD_STEPS; i++) begin
         wd_in[i] = wd_ff[i-1];
         for (int k = 0; k < 3; k++) begin
            wdiff[i][k]   = {1'b0, wrem_ff[i-1][k]}
                          - {1'b0, (64'(wd_ff[i-1]) << (WD_STEPS - i))};
            wrem_in[i][k] = wdiff[i][k][64] ? wrem_ff[i-1][k] : wdiff[i][k][63:0];
            wq_in[i][k]   = {wq_ff[i-1][k][WD_STEPS-2:0], !wdiff[i][k][64]};
         end
      end

      for (int k = 0; k < 3; k++) begin
         prod_in[k] = $signed({1'b0, wq_ff[WD_STEPS][k]}) * cand_ff[CAND_DLY-3][k];
      end
      acc   = 56'(prod_ff[0]) + 56'(prod_ff[1]) + 56'(prod_ff[2]) + 56'sd524288;
      rs_in = 36'(acc >>> 20);

      // fields a mode does not compute read as zero
      rsp_in = '0;
      if (op_ff[OP_DLY-1] == OP_CAND || op_ff[OP_DLY-1] == OP_FULL) begin
         rsp_in.cand0 = cand_ff[CAND_DLY-1][0];
         rsp_in.cand1 = cand_ff[CAND_DLY-1][1];
         rsp_in.cand2 = cand_ff[CAND_DLY-1][2];
      end
      if (op_ff[OP_DLY-1] == OP_WEIGHT || op_ff[OP_DLY-1] == OP_FULL) begin
         rsp_in.weight0 = wt55_ff[0];
         rsp_in.weight1 = wt55_ff[1];
         rsp_in.weight2 = wt55_ff[2];
      end
      if (op_ff[OP_DLY-1] == OP_FULL) begin
         rsp_in.recon_value = sat32(40'(rs_ff));
      end
   end

   // datapath registers, no reset
   always_ff @(posedge clock) begin
      if (adv) begin
         in_ff <= req_data;
         for (int i = 0; i < OP_DLY; i++) begin
            op_ff[i] <= op_in[i];
         end
         for (int j = 0; j < 6; j++) begin
            tt_ff[j]   <= tt_in[j];
            tlow_ff[j] <= tlow_in[j];
            tbig_ff[j] <= tbig_in[j];
            sq_ff[j]   <= sq_in[j];
         end
         for (int k = 0; k < 3; k++) begin
            num_ff[k]     <= num_in[k];
            cmag_ff[k]    <= cmag_in[k];
            cneg_ff[k]    <= cneg_in[k];
            cq_ff[k]      <= cq_in[k];
            cneg3_ff[k]   <= cneg_ff[k];
            s1q_ff[k]     <= s1q_in[k];
            s2_ff[k]      <= s2_in[k];
            q12_ff[k]     <= q12_in[k];
            x_ff[k]       <= x_in[k];
            s1q5_ff[k]    <= s1q_ff[k];
            beta_ff[k]    <= beta_in[k];
            b_ff[k]       <= b_in[k];
            r2_ff[k]      <= r2_in[k];
            alpha_ff[k]   <= alpha_in[k];
            alpha31_ff[k] <= alpha_ff[k];
            prod_ff[k]    <= prod_in[k];
            wt_ff[k]      <= wq_ff[WD_STEPS][k];
            wt55_ff[k]    <= wt_ff[k];
         end
         for (int d = 0; d < CAND_DLY; d++) begin
            for (int k = 0; k < 3; k++) begin
               cand_ff[d][k] <= cand_in[d][k];
            end
         end
         for (int j = 0; j <= RD_STEPS; j++) begin
            for (int k = 0; k < 3; k++) begin
               rrem_ff[j][k] <= rrem_in[j][k];
               rb_ff[j][k]   <= rb_in[j][k];
               rq_ff[j][k]   <= rq_in[j][k];
               rone_ff[j][k] <= rone_in[j][k];
            end
         end
         for (int i = 0; i <= WD_STEPS; i++) begin
            wd_ff[i] <= wd_in[i];
            for (int k = 0; k < 3; k++) begin
               wrem_ff[i][k] <= wrem_in[i][k];
               wq_ff[i][k]   <= wq_in[i][k];
            end
         end
         asum_ff <= asum_in;
         rs_ff   <= rs_in;
         rsp_ff  <= rsp_in;
      end
   end

   assign rsp_valid = vld_ff[STG_LAST];
   assign rsp_data  = rsp_ff;

   // a held output freezes every stage valid bit
   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline moved while output stalled");

   // the smallest indicator always yields a full ratio
   a_min_found: assert property (@(posedge clock) disable iff (reset)
      vld_ff[8] |-> (rone_ff[0][0] || rone_ff[0][1] || rone_ff[0][2]))
      else $error("no indicator matched the minimum");

   // rounded weight quotients stay within one
   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[53] |-> (wq_ff[WD_STEPS][0] <= 21'h100000 && wq_ff[WD_STEPS][1] <= 21'h100000
                   && wq_ff[WD_STEPS][2] <= 21'h100000))
      else $error("weight above one");

   // normalised weights sum to one within rounding
   a_weight_sum: assert property (@(posedge clock) disable iff (reset)
      vld_ff[55] |-> ((23'(wt55_ff[0]) + 23'(wt55_ff[1]) + 23'(wt55_ff[2]) >= 23'd1048575)
                   && (23'(wt55_ff[0]) + 23'(wt55_ff[1]) + 23'(wt55_ff[2]) <= 23'd1048577)))
      else $error("weights do not sum to one");

endmodule

// ===== tb/sv/weno5_reconstruction_top_tb.sv =====
// testbench for the weno5 reconstruction block: directed and random items checked by a predictor
`timescale 1ns / 1ps

module weno5_reconstruction_top_tb;
   import weno5_pkg::*;

   // operation code with no computation behind it
   localparam logic [1:0] OP_SPARE = 2'd3;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   weno5_req_type req_data;
   logic          rsp_valid;
   logic          rsp_ready;
   weno5_rsp_type rsp_data;
   logic          csr_wr_en;
   logic [31:0]   csr_wr_data;

   // predictor copy of the regularizer register
   logic [31:0]   eps_model;

   weno5_rsp_type expected_rsp_q [$];
   int            mismatch_count;
   bit            sender_idles;
   bit            receiver_idles;
   bit            long_hold_req;

   weno5_reconstruction_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 12 ns clock
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------

   // divide by six, rounding ties away from zero
   function automatic longint round_sixth(input longint n);
      longint mag;
      longint q;
      mag = (n < 0) ? -n : n;
      q   = (mag + 3) / 6;
      return (n < 0) ? -q : q;
   endfunction

   function automatic longint clamp32(input longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic logic [63:0] add_clamped(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
   endfunction

   function automatic logic [63:0] square_clamped(input longint t);
      logic [63:0] mag;
      mag = (t < 0) ? -t : t;
      if (mag >= 64'h1_0000_0000) return 64'hFFFF_FFFF_FFFF_FFFF;
      return mag * mag;
   endfunction

   // jiang-shu indicator from the two difference terms
   function automatic logic [63:0] indicator(input longint t1, input longint t2);
      logic [63:0] s1;
      logic [63:0] s2;
      s1 = square_clamped(t1);
      s2 = square_clamped(t2);
      return add_clamped(s1 >> 2, add_clamped(s2, s2 / 12));
   endfunction

   // floor(m * 2^20 / b), bit-serial with carry out of the top
   function automatic logic [63:0] ratio_q20(input logic [63:0] m, input logic [63:0] b);
      logic [63:0] rem;
      logic [63:0] q;
      logic        carry;
      if (m >= b) return 64'd1 << 20;
      rem = m;
      q   = '0;
      for (int k = 0; k < 20; k++) begin
         carry = rem[63];
         rem   = rem << 1;
         q     = q << 1;
         if (carry || rem >= b) begin
            rem  = rem - b;
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic weno5_rsp_type reconstruct(input weno5_req_type it);
      weno5_rsp_type r;
      longint        fm2, fm1, f0, fp1, fp2;
      longint        cand [3];
      logic [63:0]   beta [3];
      logic [63:0]   alpha [3];
      logic [63:0]   wt [3];
      logic [63:0]   lo;
      logic [63:0]   rk;
      logic [63:0]   total;
      longint        acc;
      longint        t;
      longint        recon;
      logic [63:0]   ideal [3];
      ideal = '{64'd1, 64'd6, 64'd3};
      r     = '0;
      recon = 0;
      wt    = '{64'd0, 64'd0, 64'd0};
      f0    = longint'(it.sample_center);
      if (it.direction) begin
         fm2 = longint'(it.sample_p2);
         fm1 = longint'(it.sample_p1);
         fp1 = longint'(it.sample_m1);
         fp2 = longint'(it.sample_m2);
      end else begin
         fm2 = longint'(it.sample_m2);
         fm1 = longint'(it.sample_m1);
         fp1 = longint'(it.sample_p1);
         fp2 = longint'(it.sample_p2);
      end
      cand[0] = clamp32(round_sixth(2 * fm2 - 7 * fm1 + 11 * f0));
      cand[1] = clamp32(round_sixth(-fm1 + 5 * f0 + 2 * fp1));
      cand[2] = clamp32(round_sixth(2 * f0 + 5 * fp1 - fp2));
      if (it.operation == OP_WEIGHT || it.operation == OP_FULL) begin
         beta[0] = add_clamped(indicator(fm2 - 4 * fm1 + 3 * f0, fm2 - 2 * fm1 + f0),
                               {32'd0, eps_model});
         beta[1] = add_clamped(indicator(fm1 - fp1, fm1 - 2 * f0 + fp1), {32'd0, eps_model});
         beta[2] = add_clamped(indicator(3 * f0 - 4 * fp1 + fp2, f0 - 2 * fp1 + fp2),
                               {32'd0, eps_model});
         lo = beta[0];
         if (beta[1] < lo) lo = beta[1];
         if (beta[2] < lo) lo = beta[2];
         total = '0;
         for (int k = 0; k < 3; k++) begin
            rk       = ratio_q20(lo, beta[k]);
            alpha[k] = ideal[k] * rk * rk;
            total    = total + alpha[k];
         end
         for (int k = 0; k < 3; k++) wt[k] = ((alpha[k] << 20) + total / 2) / total;
      end
      if (it.operation == OP_FULL) begin
         acc = 0;
         for (int k = 0; k < 3; k++) acc += longint'(wt[k]) * cand[k];
         t = acc + (64'sd1 <<< 19);
         if (t >= 0) recon = t / (64'sd1 <<< 20);
         else recon = -((-t + (64'sd1 <<< 20) - 1) / (64'sd1 <<< 20));
         recon = clamp32(recon);
      end
      if (it.operation == OP_CAND || it.operation == OP_FULL) begin
         r.cand0 = cand[0][31:0];
         r.cand1 = cand[1][31:0];
         r.cand2 = cand[2][31:0];
      end
      r.weight0     = wt[0][20:0];
      r.weight1     = wt[1][20:0];
      r.weight2     = wt[2][20:0];
      r.recon_value = recon[31:0];
      return r;
   endfunction

   // ---------------------------------------------------------------
   // shared driving and checking
   // ---------------------------------------------------------------

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   // offer one item, optionally after a random idle burst
   task automatic send_item(input weno5_req_type it);
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      expected_rsp_q.push_back(reconstruct(it));
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic stop_sending;
      req_valid <= 1'b0;
   endtask

   // wait for the pipeline to drain, then give it the latency once more
   task automatic drain;
      int guard;
      guard = 0;
      while (expected_rsp_q.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (70) @(posedge clock);
   endtask

   task automatic write_epsilon(input logic [31:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      eps_model = value;
   endtask

   // receiver: random stalls, plus one long hold when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (long_hold_req) begin
         rsp_ready <= 1'b0;
      end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // result checker: compare each accepted item with the oldest prediction
   always @(posedge clock) begin
      weno5_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("unexpected item", 1, 0);
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_data.cand0 !== want.cand0)
               report_mismatch("cand0", rsp_data.cand0, want.cand0);
            if (rsp_data.cand1 !== want.cand1)
               report_mismatch("cand1", rsp_data.cand1, want.cand1);
            if (rsp_data.cand2 !== want.cand2)
               report_mismatch("cand2", rsp_data.cand2, want.cand2);
            if (rsp_data.weight0 !== want.weight0)
               report_mismatch("weight0", rsp_data.weight0, want.weight0);
            if (rsp_data.weight1 !== want.weight1)
               report_mismatch("weight1", rsp_data.weight1, want.weight1);
            if (rsp_data.weight2 !== want.weight2)
               report_mismatch("weight2", rsp_data.weight2, want.weight2);
            if (rsp_data.recon_value !== want.recon_value)
               report_mismatch("recon_value", rsp_data.recon_value, want.recon_value);
         end
      end
   end

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------

   function automatic logic [31:0] any_sample;
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         default: return $urandom_range(0, 32'h0FF_FFFF) - 32'h080_0000;
      endcase
   endfunction

   // smooth-ish profile so the weights see realistic indicators
   function automatic weno5_req_type profile_item(input logic [1:0] op);
      weno5_req_type it;
      int            base;
      int            slope;
      base  = $urandom_range(0, 32'h3FF_FFFF) - 32'h200_0000;
      slope = $urandom_range(0, 32'h3F_FFFF) - 32'h20_0000;
      it.operation     = op;
      it.direction     = 1'($urandom_range(0, 1));
      it.sample_m2     = base - 2 * slope;
      it.sample_m1     = base - slope + $urandom_range(0, 4095) - 2048;
      it.sample_center = base;
      it.sample_p1     = base + slope;
      it.sample_p2     = ($urandom_range(0, 4) == 0) ? any_sample() : base + 2 * slope;
      return it;
   endfunction

   function automatic weno5_req_type noise_item;
      weno5_req_type it;
      it.operation     = 2'($urandom_range(0, 3));
      it.direction     = 1'($urandom_range(0, 1));
      it.sample_m2     = any_sample();
      it.sample_m1     = any_sample();
      it.sample_center = any_sample();
      it.sample_p1     = any_sample();
      it.sample_p2     = any_sample();
      return it;
   endfunction

   function automatic weno5_req_type flat_item(input logic [1:0] op, input logic [31:0] v);
      weno5_req_type it;
      it.operation     = op;
      it.direction     = 1'b0;
      it.sample_m2     = v;
      it.sample_m1     = v;
      it.sample_center = v;
      it.sample_p1     = v;
      it.sample_p2     = v;
      return it;
   endfunction

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // extremes, every operation including the unused code, both directions
   task automatic test_directed;
      weno5_req_type it;
      send_item(flat_item(OP_FULL, 32'd0));
      send_item(flat_item(OP_FULL, 32'h0010_0000));
      send_item(flat_item(OP_CAND, 32'h7FFF_FFFF));
      send_item(flat_item(OP_FULL, 32'h8000_0000));
      send_item(flat_item(OP_WEIGHT, 32'hFFFF_FFFF));
      send_item(flat_item(OP_SPARE, 32'h1234_5678));
      for (int d = 0; d < 2; d++) begin
         it = '{OP_FULL, d[0], 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h7FFF_FFFF};
         send_item(it);
         it = '{OP_FULL, d[0], 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF};
         send_item(it);
         // a jump on one side only: one substencil should dominate
         it = '{OP_WEIGHT, d[0], 32'h0, 32'h0, 32'h0, 32'h0100_0000, 32'h0200_0000};
         send_item(it);
         it = '{OP_CAND, d[0], 32'd1, 32'd2, 32'd3, 32'd4, 32'd5};
         send_item(it);
         it = '{OP_SPARE, d[0], 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                32'hAAAA_AAAA};
         send_item(it);
      end
      stop_sending();
      drain();
   endtask

   // regulariser extremes: zero with flat and rough data, the largest value, one with noise items
   task automatic test_epsilon_settings;
      weno5_req_type it;
      write_epsilon(32'd0);
      send_item(flat_item(OP_FULL, 32'h0030_0000));
      send_item(flat_item(OP_WEIGHT, 32'h8000_0000));
      it = '{OP_FULL, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0010_0000, 32'h0040_0000};
      send_item(it);
      for (int i = 0; i < 20; i++) send_item(profile_item(OP_FULL));
      stop_sending();
      drain();
      write_epsilon(32'hFFFF_FFFF);
      for (int i = 0; i < 20; i++) send_item(profile_item(2'($urandom_range(0, 2))));
      stop_sending();
      drain();
      write_epsilon(32'd1);
      for (int i = 0; i < 20; i++) send_item(noise_item());
      stop_sending();
      drain();
      write_epsilon(EPS_RESET);
   endtask

   // long receiver hold while the sender keeps offering, so the pipe backs up
   task automatic test_backpressure;
      sender_idles   = 1'b0;
      long_hold_req <= 1'b1;
      fork
         begin
            repeat (150) @(posedge clock);
            long_hold_req <= 1'b0;
         end
         for (int i = 0; i < 80; i++) send_item(profile_item(2'($urandom_range(0, 2))));
      join
      stop_sending();
      sender_idles = 1'b1;
      drain();
   endtask

   // random mix, mostly smooth profiles, a random regulariser midway, then a final stretch with no idling
   task automatic test_random;
      for (int i = 0; i < 250; i++) begin
         if ($urandom_range(0, 9) < 7) send_item(profile_item(2'($urandom_range(0, 2))));
         else send_item(noise_item());
         if (i == 120) begin
            stop_sending();
            drain();
            write_epsilon($urandom);
         end
      end
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      for (int i = 0; i < 60; i++) send_item(profile_item(OP_FULL));
      stop_sending();
      drain();
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      long_hold_req  = 1'b0;
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      mismatch_count = 0;
      eps_model      = EPS_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_epsilon_settings();
      test_backpressure();
      test_random();

      // anything still waiting means a lost item
      if (expected_rsp_q.size() != 0) report_mismatch("missing items", 0,
                                                      expected_rsp_q.size());
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/weno5_pkg.sv
rtl/weno5_reconstruction_top.sv
tb/sv/weno5_reconstruction_top_tb.sv
